[rtl/vgn_pkg.sv]
// ----------------------------------------------------------------------------
// Voxel gradient normal package
// Shared widths, codes, state encoding and the divider interface types.
// ----------------------------------------------------------------------------
package vgn_pkg;

  localparam int GW    = 6;
  localparam int SW    = 16;
  localparam int VW    = SW + 1;
  localparam int SIZEW = 7;
  localparam int SPW   = 16;
  localparam int LIMW  = 11;
  localparam int MAGW  = 41;
  localparam int DVW   = 45;
  localparam int DSW   = 32;
  localparam int SQW   = 64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [SW-1:0] ONE_Q14 = 16'd16384;

  typedef enum logic [2:0] {
    REG_SIZE_X    = 3'd0,
    REG_SIZE_Y    = 3'd1,
    REG_SIZE_Z    = 3'd2,
    REG_SPACING_X = 3'd3,
    REG_SPACING_Y = 3'd4,
    REG_SPACING_Z = 3'd5
  } vgn_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_RDLAST,
    ST_GRAD,
    ST_GDIV,
    ST_MAX,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_NDIV_GO,
    ST_NDIV,
    ST_RESULT
  } vgn_state_t;

  typedef struct packed {
    logic           start;
    logic [DVW-1:0] dividend;
    logic [DSW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/vgn_div.sv]
// ----------------------------------------------------------------------------
// Voxel gradient normal divider
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vgn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vgn_pkg::div_req_t         req,
  output vgn_pkg::div_stat_t        stat,
  output logic [vgn_pkg::DVW-1:0]   quot
);
  import vgn_pkg::*;

  localparam int CW = $clog2(DVW + 1);

  logic [CW-1:0]  cnt_r;
  logic           done_r;
  logic [DSW-1:0] rem_r;
  logic [DSW-1:0] dsr_r;
  logic [DVW-1:0] q_r;
  logic [DSW:0]   trial;
  logic           ge;

  assign trial = {rem_r, q_r[DVW-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && (cnt_r == CW'(1));
      if (req.start) begin
        cnt_r <= CW'(DVW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      q_r   <= req.dividend;
      dsr_r <= req.divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? DSW'(trial - {1'b0, dsr_r}) : trial[DSW-1:0];
      q_r   <= {q_r[DVW-2:0], ge};
    end
  end

  assign stat.busy = cnt_r != '0;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

[rtl/voxel_gradient_normal.sv]
// A voxel write is stored on acceptance; a query result follows the read, gradient, square
// root and division steps, ends early when degenerate, and an index error skips them all.
// Throughput: one write per cycle while idle; queries run one at a time, paced by the
// bit-serial divider (up to six divisions) and the iterative square root.
// Reset: synchronous, active low; sizes return to 64 and spacings to 1.0.
// The voxel memory is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
// Voxel gradient normal
// Voxel store with central difference gradient and vector normalization.
// ----------------------------------------------------------------------------
module voxel_gradient_normal #(
  parameter int MAX_X = 64,
  parameter int MAX_Y = 64,
  parameter int MAX_Z = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // grid_x, grid_y, grid_z, sample, sample_missing
  input  logic [39:0] in_tdata,
  // operation
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // normal_x, normal_y, normal_z
  output logic [47:0] out_tdata,
  // degenerate, index_error
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import vgn_pkg::*;

  localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int SY    = MAX_X;
  localparam int SZ    = MAX_X * MAX_Y;

  vgn_state_t state_r, state_nxt;

  logic [SIZEW-1:0] size_x_r, size_y_r, size_z_r;
  logic [SPW-1:0]   spacing_x_r, spacing_y_r, spacing_z_r;

  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rd_data_r;
  logic          rd_v_r;
  logic [2:0]    rd_k_r;
  logic [2:0]    rdk_r;
  logic [AW-1:0] raddr;

  logic [GW-1:0] in_x, in_y, in_z;
  logic [AW-1:0] in_addr;
  logic [LIMW-1:0] lim_x, lim_y, lim_z;
  logic          in_range, in_store, acc_in, mem_we;

  logic [AW-1:0] caddr_r;
  logic [2:0]    use_m_r, use_p_r;
  logic [VW-1:0] vox_r [7];
  logic [1:0]    ax_r;
  logic          ie_r, deg_r;
  logic [MAGW-1:0] mag_r [3];
  logic [2:0]    neg_r;
  logic [MAGW-1:0] m_r;
  logic [1:0]    sqk_r;
  logic [59:0]   mul_r;
  logic [SQW-1:0] acc_r, sv_r, sr_r, sb_r;
  logic [DSW-1:0] len_r;
  logic [SW-1:0] nrm_r [3];
  logic          out_tvalid_r;
  logic [47:0]   out_tdata_r;
  logic [1:0]    out_tuser_r;

  logic [VW-1:0]  g_wm, g_wp, g_vm, g_vp;
  logic [SPW-1:0] g_sp;
  logic           g_um, g_up, g_usedm, g_usedp, g_deg;
  logic [17:0]    g_den;
  logic [16:0]    g_diff, g_ad;
  logic [MAGW-1:0] mag_sel, m_max01, m_max;
  logic [SQW-1:0] s_t;
  logic           s_ge;
  logic [SW-1:0]  n_c;
  logic           n_neg;
  logic           out_free;

  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [DVW-1:0]    div_quot;

  vgn_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .stat (div_stat),
    .quot (div_quot)
  );

  // Configuration port.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r    <= SIZEW'(64);
      size_y_r    <= SIZEW'(64);
      size_z_r    <= SIZEW'(64);
      spacing_x_r <= SPW'(256);
      spacing_y_r <= SPW'(256);
      spacing_z_r <= SPW'(256);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_paddr[4:2])
        REG_SIZE_X:    size_x_r    <= cfg_pwdata[SIZEW-1:0];
        REG_SIZE_Y:    size_y_r    <= cfg_pwdata[SIZEW-1:0];
        REG_SIZE_Z:    size_z_r    <= cfg_pwdata[SIZEW-1:0];
        REG_SPACING_X: spacing_x_r <= cfg_pwdata[SPW-1:0];
        REG_SPACING_Y: spacing_y_r <= cfg_pwdata[SPW-1:0];
        REG_SPACING_Z: spacing_z_r <= cfg_pwdata[SPW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_SIZE_X:    cfg_prdata = 32'(size_x_r);
      REG_SIZE_Y:    cfg_prdata = 32'(size_y_r);
      REG_SIZE_Z:    cfg_prdata = 32'(size_z_r);
      REG_SPACING_X: cfg_prdata = 32'(spacing_x_r);
      REG_SPACING_Y: cfg_prdata = 32'(spacing_y_r);
      REG_SPACING_Z: cfg_prdata = 32'(spacing_z_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // Input decode and grid checks.
  assign in_x = in_tdata[5:0];
  assign in_y = in_tdata[11:6];
  assign in_z = in_tdata[17:12];

  assign in_addr = AW'(in_x) + AW'(SY) * AW'(in_y) + AW'(SZ) * AW'(in_z);

  assign lim_x = (LIMW'(size_x_r) < LIMW'(MAX_X)) ? LIMW'(size_x_r) : LIMW'(MAX_X);
  assign lim_y = (LIMW'(size_y_r) < LIMW'(MAX_Y)) ? LIMW'(size_y_r) : LIMW'(MAX_Y);
  assign lim_z = (LIMW'(size_z_r) < LIMW'(MAX_Z)) ? LIMW'(size_z_r) : LIMW'(MAX_Z);

  assign in_range = (LIMW'(in_x) < lim_x) && (LIMW'(in_y) < lim_y) && (LIMW'(in_z) < lim_z);
  assign in_store = (LIMW'(in_x) < LIMW'(MAX_X)) && (LIMW'(in_y) < LIMW'(MAX_Y)) &&
                    (LIMW'(in_z) < LIMW'(MAX_Z));

  assign in_tready = state_r == ST_IDLE;
  assign acc_in    = in_tvalid && in_tready;
  assign mem_we    = acc_in && (in_tuser == OP_WRITE) && in_store;

  // Voxel memory.
  always_comb begin
    unique case (rdk_r)
      3'd1:    raddr = caddr_r - AW'(1);
      3'd2:    raddr = caddr_r + AW'(1);
      3'd3:    raddr = caddr_r - AW'(SY);
      3'd4:    raddr = caddr_r + AW'(SY);
      3'd5:    raddr = caddr_r - AW'(SZ);
      3'd6:    raddr = caddr_r + AW'(SZ);
      default: raddr = caddr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_addr] <= {in_tdata[34], in_tdata[33:18]};
    end
    if (state_r == ST_READ) begin
      rd_data_r <= mem[raddr];
    end
  end

  // Axis selection for the gradient and normalization steps.
  always_comb begin
    unique case (ax_r)
      2'd0: begin
        g_wm = vox_r[1]; g_wp = vox_r[2]; g_sp = spacing_x_r;
        g_um = use_m_r[0]; g_up = use_p_r[0];
        mag_sel = mag_r[0]; n_neg = neg_r[0];
      end
      2'd1: begin
        g_wm = vox_r[3]; g_wp = vox_r[4]; g_sp = spacing_y_r;
        g_um = use_m_r[1]; g_up = use_p_r[1];
        mag_sel = mag_r[1]; n_neg = neg_r[1];
      end
      default: begin
        g_wm = vox_r[5]; g_wp = vox_r[6]; g_sp = spacing_z_r;
        g_um = use_m_r[2]; g_up = use_p_r[2];
        mag_sel = mag_r[2]; n_neg = neg_r[2];
      end
    endcase
  end

  assign g_usedm = g_um && !g_wm[VW-1];
  assign g_usedp = g_up && !g_wp[VW-1];
  assign g_vm    = g_usedm ? g_wm : vox_r[0];
  assign g_vp    = g_usedp ? g_wp : vox_r[0];
  assign g_deg   = g_vm[VW-1] || g_vp[VW-1] || !(g_usedm || g_usedp) || (g_sp == '0);
  assign g_den   = (g_usedm && g_usedp) ? {1'b0, g_sp, 1'b0} : {2'b00, g_sp};
  assign g_diff  = {g_vp[SW-1], g_vp[SW-1:0]} - {g_vm[SW-1], g_vm[SW-1:0]};
  assign g_ad    = g_diff[16] ? 17'(-g_diff) : g_diff;

  assign m_max01 = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign m_max   = (m_max01 > mag_r[2]) ? m_max01 : mag_r[2];

  assign s_t  = sr_r + sb_r;
  assign s_ge = sv_r >= s_t;

  assign n_c = (div_quot > DVW'(ONE_Q14)) ? ONE_Q14 : div_quot[SW-1:0];

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = (DVW'(mag_sel[29:0]) << 14) + DVW'(len_r >> 1);
    div_req.divisor  = len_r;
    if (state_r == ST_GRAD) begin
      div_req.start    = !g_deg;
      div_req.dividend = (DVW'(g_ad) << 25) + DVW'(g_den);
      div_req.divisor  = DSW'({g_den, 1'b0});
    end else if (state_r == ST_NDIV_GO) begin
      div_req.start = 1'b1;
    end
  end

  assign out_free = !out_tvalid_r || out_tready;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_in && (in_tuser == OP_QUERY)) begin
          state_nxt = in_range ? ST_READ : ST_RESULT;
        end
      end
      ST_READ: begin
        if (rdk_r == 3'd6) begin
          state_nxt = ST_RDLAST;
        end
      end
      ST_RDLAST: state_nxt = ST_GRAD;
      ST_GRAD:   state_nxt = g_deg ? ST_RESULT : ST_GDIV;
      ST_GDIV: begin
        if (div_stat.done) begin
          state_nxt = (ax_r == 2'd2) ? ST_MAX : ST_GRAD;
        end
      end
      ST_MAX:    state_nxt = (m_max == '0) ? ST_RESULT : ST_NORM;
      ST_NORM: begin
        if (m_r[MAGW-1:30] == '0 && m_r[29]) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sqk_r == 2'd3) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sb_r == '0) begin
          state_nxt = ST_NDIV_GO;
        end
      end
      ST_NDIV_GO: state_nxt = ST_NDIV;
      ST_NDIV: begin
        if (div_stat.done) begin
          state_nxt = (ax_r == 2'd2) ? ST_RESULT : ST_NDIV_GO;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_v_r <= state_r == ST_READ;
      if (state_r == ST_RESULT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_k_r <= rdk_r;
    if (rd_v_r) begin
      vox_r[rd_k_r] <= rd_data_r;
    end
    unique case (state_r)
      ST_IDLE: begin
        caddr_r    <= in_addr;
        use_m_r    <= {in_z != '0, in_y != '0, in_x != '0};
        use_p_r    <= {(LIMW'(in_z) + LIMW'(1)) < lim_z, (LIMW'(in_y) + LIMW'(1)) < lim_y,
                       (LIMW'(in_x) + LIMW'(1)) < lim_x};
        ie_r       <= !in_range;
        deg_r      <= 1'b0;
        rdk_r      <= '0;
        ax_r       <= '0;
      end
      ST_READ: rdk_r <= rdk_r + 3'd1;
      ST_RDLAST: ax_r <= '0;
      ST_GRAD: begin
        deg_r       <= g_deg;
        neg_r[ax_r] <= g_diff[16];
      end
      ST_GDIV: begin
        if (div_stat.done) begin
          mag_r[ax_r] <= div_quot[MAGW-1:0];
          ax_r        <= ax_r + 2'd1;
        end
      end
      ST_MAX: begin
        m_r   <= m_max;
        deg_r <= m_max == '0;
        sqk_r <= '0;
        acc_r <= '0;
      end
      ST_NORM: begin
        if (m_r[MAGW-1:30] != '0) begin
          m_r      <= m_r >> 1;
          mag_r[0] <= mag_r[0] >> 1;
          mag_r[1] <= mag_r[1] >> 1;
          mag_r[2] <= mag_r[2] >> 1;
        end else if (!m_r[29]) begin
          m_r      <= m_r << 1;
          mag_r[0] <= mag_r[0] << 1;
          mag_r[1] <= mag_r[1] << 1;
          mag_r[2] <= mag_r[2] << 1;
        end
      end
      ST_SQ: begin
        unique case (sqk_r)
          2'd0:    mul_r <= mag_r[0][29:0] * mag_r[0][29:0];
          2'd1:    mul_r <= mag_r[1][29:0] * mag_r[1][29:0];
          default: mul_r <= mag_r[2][29:0] * mag_r[2][29:0];
        endcase
        if (sqk_r != 2'd0) begin
          acc_r <= acc_r + SQW'(mul_r);
        end
        sqk_r <= sqk_r + 2'd1;
        sv_r  <= acc_r + SQW'(mul_r);
        sr_r  <= '0;
        sb_r  <= SQW'(1) << 62;
      end
      ST_SQRT: begin
        if (sb_r != '0) begin
          if (s_ge) begin
            sv_r <= sv_r - s_t;
            sr_r <= (sr_r >> 1) + sb_r;
          end else begin
            sr_r <= sr_r >> 1;
          end
          sb_r <= sb_r >> 2;
        end else begin
          len_r <= sr_r[DSW-1:0];
          ax_r  <= '0;
        end
      end
      ST_NDIV_GO: ;
      ST_NDIV: begin
        if (div_stat.done) begin
          nrm_r[ax_r] <= n_neg ? SW'(-n_c) : n_c;
          ax_r        <= ax_r + 2'd1;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_tuser_r <= {ie_r, deg_r};
          out_tdata_r <= (ie_r || deg_r) ? '0 : {nrm_r[2], nrm_r[1], nrm_r[0]};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != 2'b00) |-> out_tdata == '0)
    else $error("flagged result carries nonzero components");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("degenerate and index error both set");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_stat.busy)
    else $error("divider restarted while busy");
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == 2'b00) |->
      ($signed(out_tdata[15:0]) <= 16384) && ($signed(out_tdata[15:0]) >= -16384))
    else $error("normal component out of range");
`endif

endmodule
